FILE: rtl/core/slab_slot_allocator_macros.svh
// Assertion macros for the slab slot allocator.
`ifndef SLAB_SLOT_ALLOCATOR_MACROS_SVH
`define SLAB_SLOT_ALLOCATOR_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define SSA_IMPLY(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) else $error(msg);

`endif

FILE: rtl/core/ssa_pkg.sv
// Types, codes and constants of the slab slot allocator.
package ssa_pkg;

  localparam int unsigned MAX_SLABS_DEF  = 16;
  localparam int unsigned MAX_SLOTS_DEF  = 64;
  localparam int unsigned DEF_ALIGN_LOG2 = 3;

  localparam int unsigned PTR_BYTES  = 8;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned STRIDE_W   = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOT_BYTES = 2'd0,
    CFG_SLOTS      = 2'd1,
    CFG_ALIGN      = 2'd2,
    CFG_POLICY     = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FATAL   = 2'd2,
    ST_FOREIGN = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_SEARCH,
    S_OPEN,
    S_FILL,
    S_POP_RD,
    S_POP_WR,
    S_FR_MUL,
    S_FR_CHK,
    S_FR_DIV,
    S_FR_PUSH,
    S_RESP
  } state_e;

  typedef struct packed {
    logic        cmd;
    logic [15:0] request_size;
    logic [3:0]  free_slab;
    logic [18:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slab_number;
    logic [18:0] slot_offset;
    logic [12:0] granted_size;
  } rsp_t;

endpackage

FILE: rtl/core/ssa_if.sv
// Request and response channel interfaces of the slab slot allocator.
interface ssa_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] request_size;
  logic [3:0]  free_slab;
  logic [18:0] free_offset;

  modport source (output valid, cmd, request_size, free_slab, free_offset, input ready);
  modport sink   (input valid, cmd, request_size, free_slab, free_offset, output ready);
endinterface

interface ssa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  slab_number;
  logic [18:0] slot_offset;
  logic [12:0] granted_size;

  modport source (output valid, status, slab_number, slot_offset, granted_size, input ready);
  modport sink   (input valid, status, slab_number, slot_offset, granted_size, output ready);
endinterface

FILE: rtl/core/slab_slot_allocator.sv
// Top level of the slab slot allocator: sequencer, free-list memory and slab heads.
//
// Slab slot allocator. Each request item (allocate or free) is handled one at a
// time by a small sequencer; req_i.ready is high only while the sequencer idles.
// The sequencer waits in its response state while the result register is full
// and untaken, then returns to idle before the next item can be accepted.
// An allocate scans the open slabs from the newest down for one with a free
// slot, then reads and pops the head of its free list. When no open slab has a
// free slot it opens a new slab and writes its free list, one link for each
// effective slot, one link per cycle through the single write port of the link
// memory.
// With every slab open and full, the allocate fails; a request too large, or a
// zero slot size or slot count, fails before any search.
// A free checks the slab number and offset range, then a bit-serial restoring
// divider turns the byte offset into a slot index and checks the stride
// boundary; a free of a closed slab or out-of-range offset skips the divider.
// One result item follows each request; it sits in an output register, so the
// sequencer returns to idle and takes the next request while it waits.
// After a fatal failure every request answers the fatal status until reset.
`include "slab_slot_allocator_macros.svh"

module slab_slot_allocator #(
  parameter int unsigned MaxSlabs     = ssa_pkg::MAX_SLABS_DEF,
  parameter int unsigned MaxSlots     = ssa_pkg::MAX_SLOTS_DEF,
  parameter int unsigned DefAlignLog2 = ssa_pkg::DEF_ALIGN_LOG2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ssa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ssa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  ssa_req_if.sink                      req_i,
  ssa_rsp_if.source                    rsp_o
);
  import ssa_pkg::*;

  localparam int unsigned SlabW = (MaxSlabs > 1) ? $clog2(MaxSlabs) : 1;
  localparam int unsigned OpenW = $clog2(MaxSlabs + 1);
  localparam int unsigned SlotW = $clog2(MaxSlots + 1);
  localparam int unsigned Depth = MaxSlabs * MaxSlots;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned KW    = (SlotW > 1) ? $clog2(SlotW) : 1;
  localparam int unsigned PW    = STRIDE_W + SlotW;
  localparam logic [SlotW-1:0] Empty = SlotW'(MaxSlots);

  // Configuration registers
  logic [12:0] slot_bytes_q;
  logic [6:0]  slots_q;
  logic [3:0]  align_q;
  logic [1:0]  policy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_bytes_q <= 13'd64;
      slots_q      <= 7'd64;
      align_q      <= 4'd3;
      policy_q     <= 2'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SLOT_BYTES: slot_bytes_q <= cfg_wdata_i;
        CFG_SLOTS:      slots_q      <= cfg_wdata_i[6:0];
        CFG_ALIGN:      align_q      <= cfg_wdata_i[3:0];
        CFG_POLICY:     policy_q     <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // Stride: max(slot bytes, pointer size) rounded up to the alignment.
  logic [3:0]          lg;
  logic [STRIDE_W-1:0] amask, base, stride;
  logic [SlotW-1:0]    n_eff;

  always_comb begin
    lg     = (align_q > 4'(DefAlignLog2)) ? align_q : 4'(DefAlignLog2);
    amask  = (STRIDE_W'(1) << lg) - STRIDE_W'(1);
    base   = (slot_bytes_q > 13'(PTR_BYTES)) ? STRIDE_W'(slot_bytes_q) : STRIDE_W'(PTR_BYTES);
    stride = (base + amask) & ~amask;
    n_eff  = (11'(slots_q) > 11'(MaxSlots)) ? SlotW'(MaxSlots) : SlotW'(slots_q);
  end

  // Sequencer state
  state_e              state_q, state_d;
  logic                halted_q, halted_d;
  logic [OpenW-1:0]    open_q, open_d;
  logic [SlotW-1:0]    head_q [MaxSlabs];
  logic                head_we;
  logic [SlabW-1:0]    head_widx;
  logic [SlotW-1:0]    head_wdata;
  logic [SlabW-1:0]    idx_q, idx_d, pick_q, pick_d;
  logic [SlotW-1:0]    cnt_q, cnt_d, quo_q, quo_d;
  logic [KW-1:0]       k_q, k_d;
  logic [STRIDE_W-1:0] stride_q, stride_d;
  logic [SlotW-1:0]    n_q, n_d;
  req_t                req_q, req_d;
  logic [PW-1:0]       prod_q, prod_d, dvs;
  logic [18:0]         rem_q, rem_d;
  rsp_t                res_q, res_d, out_q;
  logic                out_valid_q;
  logic                out_load;

  // Free-link memory
  logic [SlotW-1:0]    mem [Depth];
  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr, mem_raddr;
  logic [SlotW-1:0]    mem_wdata, mem_rdata_q;
  logic [SlotW-1:0]    pick_head;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  assign pick_head = head_q[pick_q];
  assign dvs       = PW'(stride_q) << k_q;
  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    halted_d   = halted_q;
    open_d     = open_q;
    idx_d      = idx_q;
    pick_d     = pick_q;
    cnt_d      = cnt_q;
    quo_d      = quo_q;
    k_d        = k_q;
    stride_d   = stride_q;
    n_d        = n_q;
    req_d      = req_q;
    prod_d     = prod_q;
    rem_d      = rem_q;
    res_d      = res_q;
    head_we    = 1'b0;
    head_widx  = pick_q;
    head_wdata = Empty;
    mem_we     = 1'b0;
    mem_waddr  = AddrW'(int'(pick_q) * MaxSlots + int'(cnt_q));
    mem_wdata  = (cnt_q == '0) ? Empty : cnt_q - SlotW'(1);
    mem_raddr  = AddrW'(int'(pick_q) * MaxSlots + int'(pick_head));
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          req_d    = '{cmd: req_i.cmd, request_size: req_i.request_size,
                       free_slab: req_i.free_slab, free_offset: req_i.free_offset};
          stride_d = stride;
          n_d      = n_eff;
          state_d  = S_PREP;
        end
      end
      S_PREP: begin
        res_d = '0;
        if (halted_q) begin
          res_d.status = ST_FATAL;
          state_d      = S_RESP;
        end else if (cmd_e'(req_q.cmd) == CMD_FREE) begin
          state_d = S_FR_MUL;
        end else if (req_q.request_size > 16'(slot_bytes_q) || slot_bytes_q == '0
                     || slots_q == '0) begin
          // Fail: answer empty or latch a halt, per policy
          res_d.status = (policy_q >= 2'd2) ? ST_FATAL : ST_EMPTY;
          halted_d     = (policy_q >= 2'd2);
          state_d      = S_RESP;
        end else if (open_q == '0) begin
          state_d = S_OPEN;
        end else begin
          idx_d   = SlabW'(open_q - OpenW'(1));
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // Scan from the newest open slab down for a nonempty free list
        if (head_q[idx_q] != Empty) begin
          pick_d  = idx_q;
          state_d = S_POP_RD;
        end else if (idx_q == '0) begin
          state_d = S_OPEN;
        end else begin
          idx_d = idx_q - SlabW'(1);
        end
      end
      S_OPEN: begin
        if (32'(open_q) >= MaxSlabs) begin
          res_d.status = (policy_q >= 2'd2) ? ST_FATAL : ST_EMPTY;
          halted_d     = (policy_q >= 2'd2);
          state_d      = S_RESP;
        end else begin
          pick_d  = SlabW'(open_q);
          cnt_d   = '0;
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        // Chain slot i to slot i-1, slot 0 ends the list
        mem_we = 1'b1;
        if (cnt_q == n_q - SlotW'(1)) begin
          head_we    = 1'b1;
          head_wdata = cnt_q;
          open_d     = open_q + OpenW'(1);
          state_d    = S_POP_RD;
        end else begin
          cnt_d = cnt_q + SlotW'(1);
        end
      end
      S_POP_RD: begin
        res_d.slot_offset = 19'(PW'(pick_head) * PW'(stride_q));
        state_d           = S_POP_WR;
      end
      S_POP_WR: begin
        head_we            = 1'b1;
        head_wdata         = mem_rdata_q;
        res_d.status       = ST_OK;
        res_d.slab_number  = 4'(pick_q);
        res_d.granted_size = slot_bytes_q;
        state_d            = S_RESP;
      end
      S_FR_MUL: begin
        prod_d  = PW'(stride_q) * PW'(n_q);
        state_d = S_FR_CHK;
      end
      S_FR_CHK: begin
        if (9'(req_q.free_slab) >= 9'(open_q) || PW'(req_q.free_offset) >= prod_q) begin
          res_d.status = ST_FOREIGN;
          state_d      = S_RESP;
        end else begin
          rem_d   = req_q.free_offset;
          quo_d   = '0;
          k_d     = KW'(SlotW - 1);
          pick_d  = SlabW'(req_q.free_slab);
          state_d = S_FR_DIV;
        end
      end
      S_FR_DIV: begin
        // One quotient bit a cycle, most significant first
        if (PW'(rem_q) >= dvs) begin
          rem_d = rem_q - 19'(dvs);
          quo_d = quo_q | (SlotW'(1) << k_q);
        end
        if (k_q == '0) begin
          state_d = S_FR_PUSH;
        end else begin
          k_d = k_q - KW'(1);
        end
      end
      S_FR_PUSH: begin
        if (rem_q != '0) begin
          res_d.status = ST_FOREIGN;
        end else begin
          mem_we       = 1'b1;
          mem_waddr    = AddrW'(int'(pick_q) * MaxSlots + int'(quo_q));
          mem_wdata    = pick_head;
          head_we      = 1'b1;
          head_wdata   = quo_q;
          res_d.status = ST_OK;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_load = (state_q == S_RESP) && (!out_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      halted_q    <= 1'b0;
      open_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MaxSlabs; i++) begin
        head_q[i] <= Empty;
      end
    end else begin
      state_q  <= state_d;
      halted_q <= halted_d;
      open_q   <= open_d;
      if (head_we) begin
        head_q[head_widx] <= head_wdata;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pick_q   <= pick_d;
    cnt_q    <= cnt_d;
    quo_q    <= quo_d;
    k_q      <= k_d;
    stride_q <= stride_d;
    n_q      <= n_d;
    req_q    <= req_d;
    prod_q   <= prod_d;
    rem_q    <= rem_d;
    res_q    <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.slab_number  = out_q.slab_number;
  assign rsp_o.slot_offset  = out_q.slot_offset;
  assign rsp_o.granted_size = out_q.granted_size;

  `SSA_ASSERT(a_halt_sticky, halted_q |=> halted_q, "halt latch dropped")
  `SSA_ASSERT(a_open_bound, 32'(open_q) <= MaxSlabs, "too many slabs open")
  `SSA_IMPLY(a_fill_room, state_q == S_FILL, 32'(open_q) < MaxSlabs, "fill beyond slab limit")
  `SSA_IMPLY(a_fail_zero, rsp_o.valid && rsp_o.status != ST_OK, rsp_o.granted_size == '0, "failed result carries a size")

endmodule
